### rtl/bsc_pkg.sv
package bsc_pkg;

	typedef struct packed {
		logic [47:0] temp_cal;
		logic [47:0] press_a;
		logic [47:0] press_b;
		logic [47:0] press_c;
	} cal_t;

	typedef struct packed {
		logic [23:0] tcent;
		logic [31:0] tfine;
		logic        zero;
	} meta_t;

	typedef struct packed {
		meta_t       meta;
		logic [63:0] num;
		logic [63:0] adiv;
	} job_t;

	typedef enum logic [1:0] {
		REG_TEMP    = 2'd0,
		REG_PRESS_A = 2'd1,
		REG_PRESS_B = 2'd2,
		REG_PRESS_C = 2'd3
	} reg_idx_t;

	localparam logic [32:0] TEMP_OFFSET = 33'd128000;
	localparam logic [11:0] DIV_SCALE   = 12'd3125;
	localparam logic [20:0] PRESS_BASE  = 21'd1048576;
	localparam logic [31:0] TEMP_ROUND  = 32'd128;
	localparam logic [63:0] ONE_Q47     = 64'h0000_8000_0000_0000;

endpackage

### rtl/bsc_fifo.sv
module bsc_fifo import bsc_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t din,
	output logic full,
	input  logic pop,
	output job_t dout,
	output logic not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign dout      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue count beyond depth");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0) else $error("pop from empty queue");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != CW'(DEPTH)) else $error("push into full queue");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count not incremented");

endmodule

### rtl/bsc_front.sv
module bsc_front import bsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cal_t        cal,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,
	output logic        push,
	output job_t        job,
	input  logic        full
);

	logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
	assign t1 = cal.temp_cal[15:0];
	assign t2 = cal.temp_cal[31:16];
	assign t3 = cal.temp_cal[47:32];
	assign p1 = cal.press_a[15:0];
	assign p2 = cal.press_a[31:16];
	assign p3 = cal.press_a[47:32];
	assign p4 = cal.press_b[15:0];
	assign p5 = cal.press_b[31:16];
	assign p6 = cal.press_b[47:32];

	logic [14:1] vld_q;
	logic        en;

	assign en       = !vld_q[14] || !full;
	assign s_tready = en;
	assign push     = vld_q[14] && !full;

	logic [20:0] pp_s [1:11];
	logic [23:0] tc_s [5:13];
	logic [31:0] tf_s [5:13];

	logic [17:0] d1_s1;
	logic [16:0] d2_s1;
	logic [31:0] m1_s2, sq_s2;
	logic [31:0] tv1_s3, m3_s3;
	logic [31:0] tfine_s4;
	logic [32:0] a_s5;
	logic [63:0] aa_s6;
	logic [48:0] ap5_s6, ap2_s6, ap5_s7, ap2_s7, ap5_s8, ap2_s8;
	logic [48:0] lo6_s7, lo3_s7;
	logic [31:0] hi6_s7, hi3_s7;
	logic [63:0] aap6_s8, aap3_s8;
	logic [63:0] b_s9, x_s9, b_s10, y_s10, b_s11;
	logic [47:0] ylo_s11;
	logic [31:0] yhi_s11;
	logic [63:0] adiv_s12, n0_s12, adiv_s13;
	logic [43:0] nlo_s13;
	logic [31:0] nhi_s13;
	job_t        job_s14;

	logic signed [33:0] m1_w, sq_w;
	logic signed [35:0] m3_w;
	logic        [31:0] t5_w;
	logic signed [65:0] aa_w;
	logic signed [48:0] ap5_w, ap2_w, lo6_w, lo3_w;
	logic        [31:0] hi6_w, hi3_w;
	logic        [47:0] ylo_w;
	logic        [31:0] yhi_w;
	logic        [63:0] prod_w;
	logic        [43:0] nlo_w;
	logic        [31:0] nhi_w;

	assign m1_w  = $signed(d1_s1) * $signed(t2);
	assign sq_w  = $signed(d2_s1) * $signed(d2_s1);
	assign m3_w  = $signed(sq_s2[31:12]) * $signed(t3);
	assign t5_w  = {tfine_s4[29:0], 2'b00} + tfine_s4 + TEMP_ROUND;
	assign aa_w  = $signed(a_s5) * $signed(a_s5);
	assign ap5_w = $signed(a_s5) * $signed(p5);
	assign ap2_w = $signed(a_s5) * $signed(p2);
	assign lo6_w = $signed({1'b0, aa_s6[31:0]}) * $signed(p6);
	assign lo3_w = $signed({1'b0, aa_s6[31:0]}) * $signed(p3);
	assign hi6_w = aa_s6[63:32] * {{16{p6[15]}}, p6};
	assign hi3_w = aa_s6[63:32] * {{16{p3[15]}}, p3};
	assign ylo_w = y_s10[31:0] * p1;
	assign yhi_w = y_s10[63:32] * {16'b0, p1};
	assign prod_w = {16'b0, ylo_s11} + {yhi_s11, 32'b0};
	assign nlo_w = n0_s12[31:0] * DIV_SCALE;
	assign nhi_w = n0_s12[63:32] * {20'b0, DIV_SCALE};

	always_ff @(posedge clk) begin
		if (en) begin
			// temperature path
			pp_s[1]  <= PRESS_BASE - {1'b0, s_tdata[19:0]};
			d1_s1    <= {1'b0, s_tdata[39:23]} - {1'b0, t1, 1'b0};
			d2_s1    <= {1'b0, s_tdata[39:24]} - {1'b0, t1};
			m1_s2    <= m1_w[31:0];
			sq_s2    <= sq_w[31:0];
			tv1_s3   <= {{11{m1_s2[31]}}, m1_s2[31:11]};
			m3_s3    <= m3_w[31:0];
			tfine_s4 <= tv1_s3 + {{14{m3_s3[31]}}, m3_s3[31:14]};
			tc_s[5]  <= t5_w[31:8];
			tf_s[5]  <= tfine_s4;
			a_s5     <= {tfine_s4[31], tfine_s4} - TEMP_OFFSET;
			// divisor and numerator terms
			aa_s6    <= aa_w[63:0];
			ap5_s6   <= ap5_w;
			ap2_s6   <= ap2_w;
			lo6_s7   <= lo6_w;
			lo3_s7   <= lo3_w;
			hi6_s7   <= hi6_w;
			hi3_s7   <= hi3_w;
			ap5_s7   <= ap5_s6;
			ap2_s7   <= ap2_s6;
			aap6_s8  <= {{15{lo6_s7[48]}}, lo6_s7} + {hi6_s7, 32'b0};
			aap3_s8  <= {{15{lo3_s7[48]}}, lo3_s7} + {hi3_s7, 32'b0};
			ap5_s8   <= ap5_s7;
			ap2_s8   <= ap2_s7;
			b_s9     <= aap6_s8 + ({{15{ap5_s8[48]}}, ap5_s8} << 17)
				+ ({{48{p4[15]}}, p4} << 35);
			x_s9     <= {{8{aap3_s8[63]}}, aap3_s8[63:8]}
				+ ({{15{ap2_s8[48]}}, ap2_s8} << 12);
			y_s10    <= x_s9 + ONE_Q47;
			b_s10    <= b_s9;
			ylo_s11  <= ylo_w;
			yhi_s11  <= yhi_w;
			b_s11    <= b_s10;
			adiv_s12 <= {{33{prod_w[63]}}, prod_w[63:33]};
			n0_s12   <= ({43'b0, pp_s[11]} << 31) - b_s11;
			nlo_s13  <= nlo_w;
			nhi_s13  <= nhi_w;
			adiv_s13 <= adiv_s12;
			job_s14.num        <= {20'b0, nlo_s13} + {nhi_s13, 32'b0};
			job_s14.adiv       <= adiv_s13;
			job_s14.meta.zero  <= (adiv_s13 == '0);
			job_s14.meta.tcent <= tc_s[13];
			job_s14.meta.tfine <= tf_s[13];
			for (int k = 2; k <= 11; k++) begin
				pp_s[k] <= pp_s[k-1];
			end
			for (int k = 6; k <= 13; k++) begin
				tc_s[k] <= tc_s[k-1];
				tf_s[k] <= tf_s[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[13:1], s_tvalid};
		end
	end

	assign job = job_s14;

endmodule

### rtl/bsc_back.sv
module bsc_back import bsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cal_t        cal,
	input  logic        job_valid,
	input  job_t        job,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,
	output logic        m_tuser
);

	logic [15:0] p7, p8, p9;
	assign p7 = cal.press_c[15:0];
	assign p8 = cal.press_c[31:16];
	assign p9 = cal.press_c[47:32];

	logic [71:0] vld_q;
	logic        en;

	assign en       = !vld_q[71] || m_tready;
	assign pop      = en && job_valid;
	assign m_tvalid = vld_q[71];

	meta_t       meta_s  [0:70];
	logic [63:0] rem_s   [0:63];
	logic [63:0] dq_s    [0:64];
	logic [63:0] mb_s    [0:63];
	logic        qneg_s  [0:64];
	logic [64:0] trial_w [0:63];
	logic        fit_w   [0:63];
	logic [63:0] nrem_w  [0:62];

	// restoring divide, one quotient bit per stage
	always_comb begin
		for (int k = 0; k < 64; k++) begin
			trial_w[k] = {rem_s[k], dq_s[k][63]};
			fit_w[k]   = (trial_w[k] >= {1'b0, mb_s[k]});
		end
		for (int k = 0; k < 63; k++) begin
			nrem_w[k] = fit_w[k] ? (trial_w[k][63:0] - mb_s[k]) : trial_w[k][63:0];
		end
	end

	logic [63:0] q_w;
	assign q_w = qneg_s[64] ? (64'd0 - dq_s[64]) : dq_s[64];

	logic [63:0] p_s1, ps_s1, p_s2, ps_s2, p_s3, ps_s3, p_s4, p_s5;
	logic [48:0] l9_s2, l8_s2;
	logic [31:0] h9_s2, h8_s2;
	logic [63:0] m9_s3, c2f_s3;
	logic [63:0] ll_s4, c2_s4, c2_s5;
	logic [31:0] lh_s4, hl_s4;
	logic [63:0] c1f_s5;
	logic [63:0] sum_s6;
	logic [87:0] tdata_q;
	logic        tuser_q;

	logic signed [48:0] l9_w, l8_w;
	logic        [31:0] h9_w, h8_w;
	logic        [63:0] ll_w;
	logic        [31:0] lh_w, hl_w;
	logic        [31:0] press_w;

	assign l9_w = $signed({1'b0, ps_s1[31:0]}) * $signed(p9);
	assign h9_w = ps_s1[63:32] * {{16{p9[15]}}, p9};
	assign l8_w = $signed({1'b0, p_s1[31:0]}) * $signed(p8);
	assign h8_w = p_s1[63:32] * {{16{p8[15]}}, p8};
	assign ll_w = m9_s3[31:0] * ps_s3[31:0];
	assign lh_w = m9_s3[31:0] * ps_s3[63:32];
	assign hl_w = m9_s3[63:32] * ps_s3[31:0];
	assign press_w = sum_s6[39:8] + {{12{p7[15]}}, p7, 4'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s[0] <= job.meta;
			rem_s[0]  <= '0;
			dq_s[0]   <= job.num[63] ? (64'd0 - job.num) : job.num;
			mb_s[0]   <= job.adiv[63] ? (64'd0 - job.adiv) : job.adiv;
			qneg_s[0] <= job.num[63] ^ job.adiv[63];
			for (int k = 0; k < 64; k++) begin
				dq_s[k+1]   <= {dq_s[k][62:0], fit_w[k]};
				qneg_s[k+1] <= qneg_s[k];
			end
			for (int k = 0; k < 63; k++) begin
				rem_s[k+1] <= nrem_w[k];
				mb_s[k+1]  <= mb_s[k];
			end
			for (int k = 1; k <= 70; k++) begin
				meta_s[k] <= meta_s[k-1];
			end
			// correction terms
			p_s1   <= q_w;
			ps_s1  <= {{13{q_w[63]}}, q_w[63:13]};
			l9_s2  <= l9_w;
			h9_s2  <= h9_w;
			l8_s2  <= l8_w;
			h8_s2  <= h8_w;
			p_s2   <= p_s1;
			ps_s2  <= ps_s1;
			m9_s3  <= {{15{l9_s2[48]}}, l9_s2} + {h9_s2, 32'b0};
			c2f_s3 <= {{15{l8_s2[48]}}, l8_s2} + {h8_s2, 32'b0};
			p_s3   <= p_s2;
			ps_s3  <= ps_s2;
			ll_s4  <= ll_w;
			lh_s4  <= lh_w;
			hl_s4  <= hl_w;
			c2_s4  <= {{19{c2f_s3[63]}}, c2f_s3[63:19]};
			p_s4   <= p_s3;
			c1f_s5 <= ll_s4 + {lh_s4 + hl_s4, 32'b0};
			c2_s5  <= c2_s4;
			p_s5   <= p_s4;
			sum_s6 <= p_s5 + {{25{c1f_s5[63]}}, c1f_s5[63:25]} + c2_s5;
			tdata_q <= {meta_s[70].zero ? 32'd0 : press_w,
				meta_s[70].tfine, meta_s[70].tcent};
			tuser_q <= meta_s[70].zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[70:0], job_valid};
		end
	end

	assign m_tdata = tdata_q;
	assign m_tuser = tuser_q;

endmodule

### rtl/barometric_sensor_compensation_core.sv
// channel | dir | tdata fields, lsb first                       | tuser
// s_      | in  | raw_pressure[19:0], raw_temperature[39:20]     | -
// m_      | out | temperature_centi[23:0], fine_temperature[55:24],| pressure_invalid
//         |     | pressure_q24_8[87:56]                          |
// cfg_    | in  | cfg_index selects register, cfg_wdata 48 bits  | -
//
// one reading per cycle sustained while m_tready is held high
// the back holds a 64-stage divider pipeline, one quotient bit per stage
// arst_n clears calibration registers, valid bits and queue pointers
// front and back stall independently around a small queue; a stalled output
// holds the back, a full queue with a finished item waiting holds s_tready low
module barometric_sensor_compensation_core import bsc_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // raw_pressure, raw_temperature
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,  // temperature_centi, fine_temperature, pressure_q24_8
	output logic        m_tuser   // pressure_invalid
);

	cal_t cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_TEMP:    cal_q.temp_cal <= cfg_wdata;
				REG_PRESS_A: cal_q.press_a  <= cfg_wdata;
				REG_PRESS_B: cal_q.press_b  <= cfg_wdata;
				REG_PRESS_C: cal_q.press_c  <= cfg_wdata;
				default:     cal_q          <= cal_q;
			endcase
		end
	end

	logic push, full, pop, not_empty;
	job_t job_in, job_out;

	bsc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cal      (cal_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.push     (push),
		.job      (job_in),
		.full     (full)
	);

	bsc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (job_in),
		.full      (full),
		.pop       (pop),
		.dout      (job_out),
		.not_empty (not_empty)
	);

	bsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cal       (cal_q),
		.job_valid (not_empty),
		.job       (job_out),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

### test/tb_barometric_sensor_compensation_core.sv
module tb_barometric_sensor_compensation_core;
	timeunit 1ns;
	timeprecision 1ps;
	import bsc_pkg::*;

	localparam int LATENCY = 87;
	localparam int IDLE_LIMIT = 20000;
	localparam logic [47:0] CAL_MAX = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [23:0] tcent;
		logic [31:0] tfine;
		logic [31:0] press;
		logic        invalid;
	} reading_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [47:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;
	logic        m_tuser;

	logic [47:0] cal_temp, cal_pa, cal_pb, cal_pc;
	reading_t    expected_readings[$];
	int          mismatches;
	int          idle_cycles;
	int          hold_off;
	bit          long_hold_req;
	bit          long_hold_done;
	bit          receiver_random;

	barometric_sensor_compensation_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [63:0] sx16(logic [47:0] r, int pos);
		logic [15:0] f;
		f = r[pos +: 16];
		return {{48{f[15]}}, f};
	endfunction

	function automatic logic [63:0] sra64(logic [63:0] x, int s);
		return $signed(x) >>> s;
	endfunction

	function automatic logic [31:0] sra32(logic [31:0] x, int s);
		return $signed(x) >>> s;
	endfunction

	function automatic reading_t compensate(logic [19:0] rp, logic [19:0] rt);
		reading_t    r;
		logic [31:0] t1, t2, t3, d1, d2, tv1, tv2, tf;
		logic [63:0] a, b, p, ps, c1, c2, na, nb, q, tf64;
		t1 = {16'd0, cal_temp[15:0]};
		t2 = 32'(sx16(cal_temp, 16));
		t3 = 32'(sx16(cal_temp, 32));
		d1 = {15'd0, rt[19:3]} - (t1 << 1);
		tv1 = sra32(d1 * t2, 11);
		d2 = {16'd0, rt[19:4]} - t1;
		tv2 = sra32(sra32(d2 * d2, 12) * t3, 14);
		tf = tv1 + tv2;
		r.tfine = tf;
		r.tcent = 24'(sra32(tf * 32'd5 + 32'd128, 8));
		tf64 = {{32{tf[31]}}, tf};
		a = tf64 - 64'd128000;
		b = a * a * sx16(cal_pb, 32);
		b = b + ((a * sx16(cal_pb, 16)) << 17);
		b = b + (sx16(cal_pb, 0) << 35);
		a = sra64(a * a * sx16(cal_pa, 32), 8) + ((a * sx16(cal_pa, 16)) << 12);
		a = sra64(((64'd1 << 47) + a) * {48'd0, cal_pa[15:0]}, 33);
		r.press = '0;
		r.invalid = (a == 0);
		if (a != 0) begin
			p = 64'd1048576 - {44'd0, rp};
			p = ((p << 31) - b) * 64'd3125;
			na = p[63] ? -p : p;
			nb = a[63] ? -a : a;
			q = na / nb;
			p = (p[63] != a[63]) ? -q : q;
			ps = sra64(p, 13);
			c1 = sra64(sx16(cal_pc, 32) * ps * ps, 25);
			c2 = sra64(sx16(cal_pc, 16) * p, 19);
			p = sra64(p + c1 + c2, 8) + (sx16(cal_pc, 0) << 4);
			r.press = p[31:0];
		end
		return r;
	endfunction

	// one register write while idle
	task automatic write_cal(reg_idx_t idx, logic [47:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TEMP:    cal_temp = val;
			REG_PRESS_A: cal_pa = val;
			REG_PRESS_B: cal_pb = val;
			REG_PRESS_C: cal_pc = val;
			default:     cal_pc = cal_pc;
		endcase
	endtask

	task automatic load_cal(logic [47:0] t, logic [47:0] pa, logic [47:0] pb,
			logic [47:0] pc);
		write_cal(REG_TEMP, t);
		write_cal(REG_PRESS_A, pa);
		write_cal(REG_PRESS_B, pb);
		write_cal(REG_PRESS_C, pc);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	// offer one reading, hold it until the transfer
	task automatic send_reading(logic [19:0] rp, logic [19:0] rt, bit gaps);
		int gap;
		gap = 0;
		if (gaps)
			gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
				: $urandom_range(0, 2);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {rt, rp};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_readings.push_back(compensate(rp, rt));
	endtask

	task automatic send_random(int n, bit gaps);
		for (int i = 0; i < n; i++)
			send_reading(20'($urandom()), 20'($urandom()), gaps);
	endtask

	function automatic logic [47:0] typical_cal(int which);
		// realistic-looking calibration words, sign bits exercised
		logic [15:0] w1, w2, w3;
		w1 = 16'($urandom_range(20000, 40000));
		w2 = 16'($urandom());
		w3 = 16'($urandom());
		if (which == 0)
			w2 = 16'($urandom_range(20000, 30000));
		return {w3, w2, w1};
	endfunction

	task automatic test_directed();
		logic [19:0] corners[5];
		corners = '{20'h00000, 20'hFFFFF, 20'h80000, 20'h7FFFF, 20'h55555};
		// reset calibration gives a zero divisor
		send_reading(20'h00000, 20'h00000, 0);
		send_reading(20'hFFFFF, 20'hFFFFF, 0);
		drain();
		load_cal({16'hFFD0, 16'd26435, 16'd27504}, {16'd3024, 16'hD6D0, 16'd36477},
			{16'hFFF9, 16'h008C, 16'd2855}, {16'h1770, 16'hC5F8, 16'h000F});
		foreach (corners[i])
			foreach (corners[j])
				if (j < 4)
					send_reading(corners[i], corners[j], 0);
		drain();
		load_cal(CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX);
		send_reading(20'hFFFFF, 20'h00000, 0);
		send_reading(20'h00000, 20'hFFFFF, 0);
		drain();
		load_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'h0001},
			{16'h8000, 16'h7FFF, 16'h8000}, {16'h7FFF, 16'h8000, 16'h7FFF});
		send_reading(20'h12345, 20'hFFFFF, 0);
		send_reading(20'hFFFFF, 20'h00000, 0);
		drain();
	endtask

	task automatic test_random_cal();
		for (int k = 0; k < 12; k++) begin
			if (k % 4 == 3)
				load_cal(48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
					48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}));
			else
				load_cal(typical_cal(0), typical_cal(1), typical_cal(2),
					typical_cal(3));
			send_random(110, 1);
			drain();
		end
	endtask

	task automatic test_backpressure();
		load_cal(typical_cal(0), typical_cal(1), typical_cal(2), typical_cal(3));
		long_hold_req = 1'b1;
		send_random(200, 0);
		drain();
		receiver_random = 0;
		send_random(150, 0);
		receiver_random = 1;
		drain();
		send_random(80, 1);
		drain();
	endtask

	always @(posedge clk) begin
		if (arst_n && long_hold_req && !long_hold_done) begin
			m_tready <= 1'b0;
			hold_off <= 300;
			long_hold_done <= 1'b1;
		end else if (!arst_n || hold_off > 0) begin
			m_tready <= 1'b0;
			if (hold_off > 0)
				hold_off <= hold_off - 1;
		end else if (!receiver_random)
			m_tready <= 1'b1;
		else if ($urandom_range(0, 49) == 0)
			hold_off <= $urandom_range(10, 60);
		else
			m_tready <= ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		reading_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[23:0], m_tdata[55:24], m_tdata[87:56], m_tuser};
			if (expected_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
			end else begin
				want = expected_readings.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch tcent %h/%h tfine %h/%h press %h/%h inv %b/%b",
							want.tcent, got.tcent, want.tfine, got.tfine,
							want.press, got.press, want.invalid, got.invalid);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_TEMP;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		hold_off = 0;
		long_hold_req = 1'b0;
		long_hold_done = 1'b0;
		receiver_random = 1;
		cal_temp = '0;
		cal_pa = '0;
		cal_pb = '0;
		cal_pc = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_cal();
		test_backpressure();
		if (mismatches == 0 && expected_readings.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

### barometric_sensor_compensation_core.f
rtl/bsc_pkg.sv
rtl/bsc_fifo.sv
rtl/bsc_front.sv
rtl/bsc_back.sv
rtl/barometric_sensor_compensation_core.sv
test/tb_barometric_sensor_compensation_core.sv
